>>> src/iib_pkg.sv
// ----------------------------------------------------------------------------
// iib_pkg
// Shared types and constants of the integral image box filter block.
// ----------------------------------------------------------------------------
package iib_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int PIXEL_BITS_DEF = 8;

   localparam int ENTRY_W  = 24;
   localparam int ROWSUM_W = 16;

   localparam logic [1:0] KIND_DX  = 2'd0;
   localparam logic [1:0] KIND_DY  = 2'd1;
   localparam logic [1:0] KIND_DXY = 2'd2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_FILTER_SIZE  = 2'd2;
   localparam logic [1:0] REG_KERNEL_KIND  = 2'd3;

   typedef struct packed {
      logic       command;
      logic [7:0] pixel;
      logic [7:0] row;
      logic [7:0] col;
   } req_type;

   typedef struct packed {
      logic signed [23:0] response;
      logic               inside_res;
   } rsp_type;

endpackage

>>> src/integral_image_box_filter_response.sv
// ----------------------------------------------------------------------------
// integral_image_box_filter_response
// Summed-area table builder and SURF box filter (Dxx, Dyy, Dxy) response.
// ----------------------------------------------------------------------------
// Usage:
//  req channel carries load and query transactions. A load (command 0) adds
//  one pixel, in row-major order, to the summed-area table held in one RAM;
//  it reads the entry above, then writes back. A query (command 1) reads
//  four table corners for each of its boxes (three for Dxx/Dyy, four for
//  Dxy) through the single RAM read port, one table corner per cycle. A query
//  whose window leaves the image skips the table reads and returns zero.
//  One transaction is worked on at a time; req_stall is high while busy.
//  rsp channel carries one result per query from an output register; a new
//  transaction is taken while a result still waits, and a finished query
//  waits for the output register to free up when the receiver stalls.
//  csr port (APB-style, always ready) holds image_width, image_height,
//  filter_size and kernel_kind; write only while idle.
//  Reset clears the row sum, control state and registers to defaults. The
//  table is undefined until loaded; no clearing pass is done.
// ----------------------------------------------------------------------------
module integral_image_box_filter_response
   import iib_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DMAX   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DIM_W  = ($clog2(DMAX + 1) > 9) ? $clog2(DMAX + 1) : 9;
   localparam int CW     = DIM_W + 2;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_LD_WR   = 3'd1;
   localparam logic [2:0] S_Q_RUN   = 3'd2;
   localparam logic [2:0] S_Q_FLUSH = 3'd3;
   localparam logic [2:0] S_Q_DONE  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [8:0]            width_ff, width_in;
   logic [8:0]            height_ff, height_in;
   logic [7:0]            size_ff, size_in;
   logic [1:0]            kind_ff, kind_in;
   logic [ROWSUM_W-1:0]   rowsum_ff, rowsum_in;
   logic [ADDR_W-1:0]     ld_addr_ff, ld_addr_in;
   logic                  ld_first_ff, ld_first_in;
   logic signed [CW-1:0]  left_ff, left_in;
   logic signed [CW-1:0]  top_ff, top_in;
   logic [6:0]            lobe_ff, lobe_in;
   logic [3:0]            step_ff, step_in;
   logic [ENTRY_W-1:0]    acc_ff, acc_in;
   logic                  inside_ff, inside_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  pend_neg_ff, pend_neg_in;
   logic                  pend_dbl_ff, pend_dbl_in;
   logic                  pend_zero_ff, pend_zero_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_fire, cfg_wr;
   logic [DIM_W-1:0]      eff_w, eff_h;
   logic                  load_ok, q_inside;
   logic [6:0]            skip;
   logic [15:0]           lobe_prod;
   logic [7:0]            pix;
   logic [ADDR_W-1:0]     req_addr;

   logic signed [CW-1:0]  a_s, sz_s, a2m1, off_dx, off_dxy, bl, bt, bw, bh, cr, cc;
   logic [1:0]            bi, ck;
   logic                  box_neg, box_dbl, c_zero;
   logic [3:0]            last_step;
   logic [ADDR_W-1:0]     q_addr;
   logic [ENTRY_W-1:0]    term;

   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_raddr;
   logic [ENTRY_W-1:0]    mem_wdata, mem_rdata;

   iib_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (ld_addr_ff),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[3:2])
         REG_IMAGE_WIDTH:  prdata = {23'd0, width_ff};
         REG_IMAGE_HEIGHT: prdata = {23'd0, height_ff};
         REG_FILTER_SIZE:  prdata = {24'd0, size_ff};
         REG_KERNEL_KIND:  prdata = {30'd0, kind_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // effective image size, clamped to the table
   assign eff_w = (DIM_W'(width_ff) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(width_ff);
   assign eff_h = (DIM_W'(height_ff) > DIM_W'(MAX_HEIGHT)) ?
                  DIM_W'(MAX_HEIGHT) : DIM_W'(height_ff);

   assign load_ok  = (DIM_W'(req_data.row) < eff_h) && (DIM_W'(req_data.col) < eff_w);
   assign skip     = size_ff[7:1];
   assign q_inside = (size_ff >= 8'd3) && (req_data.row >= {1'b0, skip})
                     && (req_data.col >= {1'b0, skip})
                     && ((DIM_W+1)'(req_data.row) + (DIM_W+1)'(skip) < (DIM_W+1)'(eff_h))
                     && ((DIM_W+1)'(req_data.col) + (DIM_W+1)'(skip) < (DIM_W+1)'(eff_w));
   // size/3 by reciprocal, exact for 8-bit sizes
   assign lobe_prod = 16'(size_ff) * 16'd171;
   assign pix       = req_data.pixel & 8'((32'd1 << PIXEL_BITS) - 32'd1);
   assign req_addr  = ADDR_W'(req_data.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(req_data.col);

   // box geometry for the current step
   assign a_s     = CW'(lobe_ff);
   assign sz_s    = CW'(size_ff);
   assign a2m1    = (a_s <<< 1) - CW'(1);
   assign off_dx  = (sz_s - a2m1) >>> 1;
   assign off_dxy = (sz_s - (a_s <<< 1) - CW'(1)) >>> 1;
   assign bi      = step_ff[3:2];
   assign ck      = step_ff[1:0];

   always_comb begin
      unique case (kind_ff)
         KIND_DX: begin
            bl      = left_ff + (bi[1] ? (a_s <<< 1) : (bi[0] ? a_s : CW'(0)));
            bt      = top_ff + off_dx;
            bw      = a_s;
            bh      = a2m1;
            box_neg = (bi == 2'd1);
            box_dbl = (bi == 2'd1);
         end
         KIND_DY: begin
            bl      = left_ff + off_dx;
            bt      = top_ff + (bi[1] ? (a_s <<< 1) : (bi[0] ? a_s : CW'(0)));
            bw      = a2m1;
            bh      = a_s;
            box_neg = (bi == 2'd1);
            box_dbl = (bi == 2'd1);
         end
         default: begin
            bl      = left_ff + off_dxy + (bi[0] ? a_s + CW'(1) : CW'(0));
            bt      = top_ff + off_dxy + (bi[1] ? a_s + CW'(1) : CW'(0));
            bw      = a_s;
            bh      = a_s;
            box_neg = bi[0] ^ bi[1];
            box_dbl = 1'b0;
         end
      endcase
   end

   assign last_step = ((kind_ff == KIND_DX) || (kind_ff == KIND_DY)) ? 4'd11 : 4'd15;
   assign cr     = ck[0] ? bt - CW'(1) : bt + bh - CW'(1);
   assign cc     = ck[1] ? bl - CW'(1) : bl + bw - CW'(1);
   assign c_zero = (cr < 0) || (cc < 0) || (cr >= CW'(MAX_HEIGHT)) || (cc >= CW'(MAX_WIDTH));
   assign q_addr = ADDR_W'(cr) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cc);

   assign mem_raddr = (state_ff == S_Q_RUN) ? q_addr : req_addr - ADDR_W'(MAX_WIDTH);
   assign mem_we    = (state_ff == S_LD_WR);
   assign mem_wdata = (ld_first_ff ? '0 : mem_rdata) + ENTRY_W'(rowsum_ff);

   assign term = pend_zero_ff ? '0 : (pend_dbl_ff ? {mem_rdata[ENTRY_W-2:0], 1'b0} : mem_rdata);

   always_comb begin
      state_in      = state_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      size_in       = size_ff;
      kind_in       = kind_ff;
      rowsum_in     = rowsum_ff;
      ld_addr_in    = ld_addr_ff;
      ld_first_in   = ld_first_ff;
      left_in       = left_ff;
      top_in        = top_ff;
      lobe_in       = lobe_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      inside_in     = inside_ff;
      pend_valid_in = 1'b0;
      pend_neg_in   = box_neg ^ ck[0] ^ ck[1];
      pend_dbl_in   = box_dbl;
      pend_zero_in  = c_zero;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      if (cfg_wr) begin
         unique case (paddr[3:2])
            REG_IMAGE_WIDTH:  width_in  = pwdata[8:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[8:0];
            REG_FILTER_SIZE:  size_in   = pwdata[7:0];
            REG_KERNEL_KIND:  kind_in   = pwdata[1:0];
            default:          ;
         endcase
      end

      if (pend_valid_ff) begin
         acc_in = pend_neg_ff ? acc_ff - term : acc_ff + term;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.command == CMD_LOAD) begin
                  if (load_ok) begin
                     rowsum_in   = (req_data.col == 8'd0) ?
                                   ROWSUM_W'(pix) : rowsum_ff + ROWSUM_W'(pix);
                     ld_addr_in  = req_addr;
                     ld_first_in = (req_data.row == 8'd0);
                     state_in    = S_LD_WR;
                  end
               end else begin
                  inside_in = q_inside;
                  acc_in    = '0;
                  step_in   = 4'd0;
                  left_in   = CW'(req_data.col) - CW'(skip);
                  top_in    = CW'(req_data.row) - CW'(skip);
                  lobe_in   = lobe_prod[15:9];
                  state_in  = q_inside ? S_Q_RUN : S_Q_DONE;
               end
            end
         end
         S_LD_WR: state_in = S_IDLE;
         S_Q_RUN: begin
            pend_valid_in = 1'b1;
            step_in       = step_ff + 4'd1;
            if (step_ff == last_step) begin
               state_in = S_Q_FLUSH;
            end
         end
         S_Q_FLUSH: state_in = S_Q_DONE;
         S_Q_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.response   = acc_ff;
               rsp_data_in.inside_res = inside_ff;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         width_ff      <= 9'd256;
         height_ff     <= 9'd256;
         size_ff       <= 8'd9;
         kind_ff       <= KIND_DX;
         rowsum_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         size_ff       <= size_in;
         kind_ff       <= kind_in;
         rowsum_ff     <= rowsum_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ld_addr_ff   <= ld_addr_in;
      ld_first_ff  <= ld_first_in;
      left_ff      <= left_in;
      top_ff       <= top_in;
      lobe_ff      <= lobe_in;
      step_ff      <= step_in;
      acc_ff       <= acc_in;
      inside_ff    <= inside_in;
      pend_neg_ff  <= pend_neg_in;
      pend_dbl_ff  <= pend_dbl_in;
      pend_zero_ff <= pend_zero_in;
      rsp_data_ff  <= rsp_data_in;
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_Q_DONE)
      else $error("result raised outside query completion");

   a_load_writes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.command == CMD_LOAD && load_ok) |=> mem_we)
      else $error("accepted load did not write the table");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_RUN) |-> (step_ff <= last_step))
      else $error("corner sequencer ran past last corner");

endmodule

>>> src/iib_ram.sv
// ----------------------------------------------------------------------------
// iib_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module iib_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> tb/sv/integral_image_box_filter_response_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integral_image_box_filter_response_tb
// Drives load and query transactions through a series of register settings
// and checks each result against the bench's summed-area table predictor or a given value.
// ----------------------------------------------------------------------------
module integral_image_box_filter_response_tb;
   import iib_pkg::*;

   localparam logic [1:0] KIND_ALIAS = 2'd3;   // unlisted code, behaves as Dxy
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   integral_image_box_filter_response uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // table predictor state
   logic [23:0] sat_mem [0:65535];
   bit          sat_written [0:65535];
   logic [15:0] row_sum;
   logic [8:0]  img_w, img_h;
   logic [7:0]  box_size;
   logic [1:0]  kind;

   rsp_type     pending_rsp [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          sender_idles = 0;
   bit          receiver_idles = 0;
   int          hold_requests = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   function automatic int eff_w();
      return (img_w > 256) ? 256 : int'(img_w);
   endfunction

   function automatic int eff_h();
      return (img_h > 256) ? 256 : int'(img_h);
   endfunction

   function automatic longint sat_at(longint r, longint c);
      if (r < 0 || c < 0 || r > 255 || c > 255) return 0;
      return longint'(sat_mem[r * 256 + c]);
   endfunction

   function automatic longint box_total(longint l, longint t, longint w, longint h);
      longint b, rt;
      b = t + h - 1;
      rt = l + w - 1;
      return sat_at(b, rt) - sat_at(t - 1, rt) - sat_at(b, l - 1) + sat_at(t - 1, l - 1);
   endfunction

   function automatic bit window_fits(int r, int c);
      int skip;
      skip = box_size / 2;
      return box_size >= 3 && r >= skip && c >= skip && r + skip < eff_h()
             && c + skip < eff_w();
   endfunction

   function automatic rsp_type hessian_response(int r, int c);
      rsp_type res;
      longint sz, a, w, h, l, t, left, top, v;
      sz = box_size;
      a = sz / 3;
      v = 0;
      res.inside_res = window_fits(r, c);
      if (res.inside_res) begin
         left = c - sz / 2;
         top = r - sz / 2;
         if (kind == KIND_DY) begin
            w = a * 2 - 1;
            l = left + (sz - w) / 2;
            v = box_total(l, top, w, a) - 2 * box_total(l, top + a, w, a)
                + box_total(l, top + 2 * a, w, a);
         end else if (kind == KIND_DX) begin
            h = a * 2 - 1;
            t = top + (sz - h) / 2;
            v = box_total(left, t, a, h) - 2 * box_total(left + a, t, a, h)
                + box_total(left + 2 * a, t, a, h);
         end else begin
            l = left + (sz - 2 * a - 1) / 2;
            t = top + (sz - 2 * a - 1) / 2;
            v = box_total(l, t, a, a) - box_total(l + a + 1, t, a, a)
                - box_total(l, t + a + 1, a, a) + box_total(l + a + 1, t + a + 1, a, a);
         end
      end
      res.response = v[23:0];
      return res;
   endfunction

   function automatic void table_load(logic [7:0] pix, int r, int c);
      logic [23:0] above;
      if (r >= eff_h() || c >= eff_w()) return;
      if (c == 0) row_sum = {8'd0, pix};
      else row_sum = row_sum + pix;
      above = (r > 0) ? sat_mem[(r - 1) * 256 + c] : 24'd0;
      sat_mem[r * 256 + c] = above + row_sum;
      sat_written[r * 256 + c] = 1;
   endfunction

   // never touch a table entry that no load has written
   function automatic bit reads_written(req_type d);
      int skip, qr, qc;
      qr = int'(d.row);
      qc = int'(d.col);
      if (d.command == CMD_LOAD) begin
         if (qr >= eff_h() || qc >= eff_w() || qr == 0) return 1;
         return sat_written[(qr - 1) * 256 + qc];
      end
      if (!window_fits(qr, qc)) return 1;
      skip = box_size / 2;
      for (int r = qr - skip - 1; r <= qr + skip; r++)
         for (int c = qc - skip - 1; c <= qc + skip; c++)
            if (r >= 0 && c >= 0 && !sat_written[r * 256 + c]) return 0;
      return 1;
   endfunction

   task automatic send(req_type d, bit typed, rsp_type want);
      rsp_type exp_rsp;
      if (sender_idles) begin
         while ($urandom_range(99) < 74) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (req_stall);
      if (d.command == CMD_QUERY) begin
         exp_rsp = typed ? want : hessian_response(d.row, d.col);
         pending_rsp = {pending_rsp, exp_rsp};
      end else
         table_load(d.pixel, d.row, d.col);
   endtask

   task automatic send_item(logic cmd, logic [7:0] pix, int r, int c);
      req_type d;
      d.command = cmd;
      d.pixel = pix;
      d.row = r[7:0];
      d.col = c[7:0];
      if (reads_written(d)) send(d, 0, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_IMAGE_WIDTH: img_w = val[8:0];
         REG_IMAGE_HEIGHT: img_h = val[8:0];
         REG_FILTER_SIZE: box_size = val[7:0];
         default: kind = val[1:0];
      endcase
   endtask

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   // directed rows under reset defaults: 256x256, size 9, Dxx
   typedef struct {
      logic       cmd;
      logic [7:0] pix;
      int         r;
      int         c;
      bit         typed;
      rsp_type    want;
   } stim_row;

   stim_row directed [] = '{
      '{CMD_QUERY, 8'd0,   0,   0,   1, '{24'd0, 1'b0}},
      '{CMD_QUERY, 8'd0,   255, 255, 1, '{24'd0, 1'b0}},
      '{CMD_QUERY, 8'd255, 3,   200, 1, '{24'd0, 1'b0}},
      '{CMD_QUERY, 8'd0,   200, 3,   1, '{24'd0, 1'b0}},
      '{CMD_QUERY, 8'd0,   252, 128, 1, '{24'd0, 1'b0}},
      '{CMD_LOAD,  8'd255, 0,   0,   0, '{24'd0, 1'b0}},
      '{CMD_LOAD,  8'd0,   0,   1,   0, '{24'd0, 1'b0}},
      '{CMD_LOAD,  8'd255, 0,   2,   0, '{24'd0, 1'b0}},
      '{CMD_LOAD,  8'd170, 0,   3,   0, '{24'd0, 1'b0}},
      '{CMD_LOAD,  8'd85,  1,   0,   0, '{24'd0, 1'b0}},
      '{CMD_QUERY, 8'd0,   128, 252, 1, '{24'd0, 1'b0}}
   };

   typedef struct {
      int         w, h, sz;
      logic [1:0] k;
   } setting_row;

   setting_row settings [] = '{
      '{16, 10, 9,   KIND_DX},
      '{10, 16, 9,   KIND_DY},
      '{10, 10, 6,   KIND_DXY},
      '{20, 6,  3,   KIND_ALIAS},
      '{1,  300, 3,  KIND_DX},
      '{511, 1, 3,   KIND_DY},
      '{7,  7,  255, KIND_DXY},
      '{9,  9,  2,   KIND_DX},
      '{0,  5,  9,   KIND_DX},
      '{13, 13, 15,  KIND_DXY},
      '{13, 11, 12,  KIND_DY},
      '{30, 4,  3,   KIND_ALIAS}
   };

   // result receiver: random stalls plus occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= receiver_idles && ($urandom_range(99) < 74);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result: response %0d inside_res %0d",
                   rsp_data.response, rsp_data.inside_res);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.response !== want.response) begin
               $error("response: expected %0d, got %0d", want.response, rsp_data.response);
               fail_count++;
            end
            if (rsp_data.inside_res !== want.inside_res) begin
               $error("inside_res: expected %0d, got %0d",
                      want.inside_res, rsp_data.inside_res);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("integral_image_box_filter_response_tb: errors");
         $finish;
      end
   end

   initial begin
      int ew, eh, r, c, pick;
      for (int i = 0; i < 65536; i++) sat_written[i] = 0;
      row_sum = '0;
      img_w = 9'd256;
      img_h = 9'd256;
      box_size = 8'd9;
      kind = KIND_DX;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_item(directed[i].cmd, directed[i].pix, directed[i].r, directed[i].c);
      foreach (directed[i])
         if (directed[i].typed) begin
            req_type d;
            d.command = directed[i].cmd;
            d.pixel = directed[i].pix;
            d.row = directed[i].r[7:0];
            d.col = directed[i].c[7:0];
            send(d, 1, directed[i].want);
         end
      drain();

      foreach (settings[p]) begin
         csr_write(REG_IMAGE_WIDTH, 32'(settings[p].w));
         csr_write(REG_IMAGE_HEIGHT, 32'(settings[p].h));
         csr_write(REG_FILTER_SIZE, 32'(settings[p].sz));
         csr_write(REG_KERNEL_KIND, {30'd0, settings[p].k});
         sender_idles = (p % 4 == 1) || (p % 4 == 3);
         receiver_idles = (p % 4 == 2) || (p % 4 == 3);
         ew = eff_w();
         eh = eff_h();
         // whole image in row-major order first
         for (r = 0; r < eh; r++)
            for (c = 0; c < ew; c++)
               send_item(CMD_LOAD, rand_pixel(), r, c);
         if (p == 2) hold_requests++;
         for (int n = 0; n < 15; n++) begin
            if (p == 1 && n == 8) begin
               req_valid <= 1'b0;
               while (pending_rsp.size() > 0) @(posedge clock);
            end
            pick = $urandom_range(99);
            if (pick < 60)
               send_item(CMD_QUERY, rand_pixel(), $urandom_range(eh + 1),
                         $urandom_range(ew + 1));
            else if (pick < 72)
               send_item(CMD_QUERY, 8'($urandom), $urandom_range(255), $urandom_range(255));
            else if (pick < 88 && ew > 0 && eh > 0)
               send_item(CMD_LOAD, rand_pixel(), $urandom_range(eh - 1),
                         $urandom_range(ew - 1));
            else
               send_item(CMD_LOAD, 8'($urandom), $urandom_range(255), $urandom_range(255));
         end
         drain();
      end

      sender_idles = 0;
      receiver_idles = 0;
      drain();
      if (fail_count == 0) begin
         $display("integral_image_box_filter_response_tb: clean");
      end else begin
         $display("integral_image_box_filter_response_tb: errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/iib_pkg.sv
src/iib_ram.sv
src/integral_image_box_filter_response.sv
tb/sv/integral_image_box_filter_response_tb.sv
